// File: src/pcc_pkg.sv
package pcc_pkg;

  localparam int NUM_PADS = 8;
  localparam int CHG_W    = 16;
  localparam int IDX_W    = $clog2(NUM_PADS);
  localparam int SUM_W    = CHG_W + IDX_W;
  localparam int WS_W     = SUM_W + IDX_W;
  localparam int START_W  = 10;
  localparam int CNT_W    = 4;
  localparam int LPO_W    = CNT_W + 1;
  localparam int SCALE_W  = 8;
  localparam int FRAC_W   = 8;
  localparam int STS_W    = START_W + SCALE_W;
  localparam int Q_W      = IDX_W + SCALE_W + FRAC_W;
  localparam int DV_W     = WS_W + SCALE_W + FRAC_W;
  localparam int CENT_W   = 26;
  localparam int TOT_W    = 19;
  localparam int CSUM_W   = ((STS_W + FRAC_W > Q_W) ? (STS_W + FRAC_W) : Q_W) + 1;
  localparam int TOTX_W   = (SUM_W > TOT_W) ? SUM_W : TOT_W;

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_STRIP_SCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PADS    = 8'd1;

  localparam logic [SCALE_W-1:0] STRIP_SCALE_RST = 8'd10;
  localparam logic [CNT_W-1:0]   MIN_PADS_RST    = 4'd2;

  localparam logic [CSUM_W-1:0] CENT_MAX = CSUM_W'((64'd1 << CENT_W) - 64'd1);
  localparam logic [TOTX_W-1:0] TOT_MAX  = TOTX_W'((64'd1 << TOT_W) - 64'd1);

  typedef logic [NUM_PADS-1:0][CHG_W-1:0] charges_t;

  typedef struct packed {
    logic [STS_W-1:0] sts;
    logic [SUM_W-1:0] sum;
    logic [WS_W-1:0]  wsum;
    logic             valid;
  } evt_t;

endpackage

// File: src/pcc_front.sv
module pcc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [pcc_pkg::START_W-1:0]     start_strip,
  input  logic [pcc_pkg::CNT_W-1:0]       pad_count,
  input  pcc_pkg::charges_t               charges,
  input  logic [pcc_pkg::SCALE_W-1:0]     strip_scale,
  input  logic [pcc_pkg::CNT_W-1:0]       min_pads,
  input  logic                            q_full,
  output logic                            q_push,
  output pcc_pkg::evt_t                   q_data
);

  logic                          accept;
  logic                          odd;
  logic [pcc_pkg::START_W-1:0]   start_adj;
  logic [pcc_pkg::LPO_W-1:0]     lpo;
  logic [pcc_pkg::NUM_PADS-1:0]  sel;
  logic                          a_vld_r;
  logic                          a_vld_nxt;
  pcc_pkg::charges_t             chg_r;
  logic [pcc_pkg::STS_W-1:0]     sts_r;
  logic                          keep_r;
  logic [pcc_pkg::SUM_W-1:0]     sum_c;
  logic [pcc_pkg::WS_W-1:0]      wsum_c;

  assign accept    = start && !busy;
  assign odd       = start_strip[0];
  assign start_adj = {start_strip[pcc_pkg::START_W-1:1], 1'b0};

  // odd start skips pad 0 and shifts the window up by one
  always_comb begin
    if (pad_count == '0) begin
      lpo = pcc_pkg::LPO_W'(odd);
    end else begin
      lpo = pcc_pkg::LPO_W'(pad_count) + pcc_pkg::LPO_W'(odd);
    end
    for (int j = 0; j < pcc_pkg::NUM_PADS; j++) begin
      sel[j] = !(odd && (j == 0)) && (pcc_pkg::LPO_W'(j) < lpo);
    end
  end

  always_comb begin
    a_vld_nxt = a_vld_r;
    if (accept) begin
      a_vld_nxt = 1'b1;
    end else if (q_push) begin
      a_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < pcc_pkg::NUM_PADS; j++) begin
        chg_r[j] <= sel[j] ? charges[j] : '0;
      end
      sts_r  <= pcc_pkg::STS_W'(start_adj) * pcc_pkg::STS_W'(strip_scale);
      keep_r <= (pad_count > min_pads) && (start_adj != '0);
    end
  end

  // plain and index-weighted sums of the selected pads
  always_comb begin
    sum_c  = '0;
    wsum_c = '0;
    for (int j = 0; j < pcc_pkg::NUM_PADS; j++) begin
      sum_c  = sum_c + pcc_pkg::SUM_W'(chg_r[j]);
      wsum_c = wsum_c + pcc_pkg::WS_W'(chg_r[j]) * pcc_pkg::WS_W'(j);
    end
  end

  assign q_push       = a_vld_r && !q_full;
  assign busy         = a_vld_r && q_full;
  assign q_data.sts   = sts_r;
  assign q_data.sum   = sum_c;
  assign q_data.wsum  = wsum_c;
  assign q_data.valid = keep_r && (sum_c != '0);

endmodule

// File: src/pcc_fifo.sv
module pcc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pcc_pkg::evt_t push_data,
  input  logic          pop,
  output pcc_pkg::evt_t head,
  output logic          not_empty,
  output logic          full
);

  pcc_pkg::evt_t                mem_r [pcc_pkg::QDEPTH];
  logic [pcc_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [pcc_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [pcc_pkg::QCNT_W-1:0]   cnt_r;
  logic [pcc_pkg::QCNT_W-1:0]   cnt_nxt;
  logic                         do_pop;

  assign full      = (cnt_r == pcc_pkg::QCNT_W'(pcc_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/pcc_back.sv
module pcc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  pcc_pkg::evt_t                 in_evt,
  input  logic [pcc_pkg::SCALE_W-1:0]   strip_scale,
  output logic                          pop,
  output logic                          res_strobe,
  output logic [pcc_pkg::CENT_W-1:0]    res_centroid,
  output logic [pcc_pkg::TOT_W-1:0]     res_total,
  output logic                          res_cvalid
);

  localparam int NS = pcc_pkg::Q_W;

  logic [pcc_pkg::WS_W+pcc_pkg::SCALE_W-1:0] prod;
  logic [pcc_pkg::DV_W-1:0]                  dvd;

  logic                          vld_r [0:NS];
  logic [pcc_pkg::SUM_W-1:0]     rem_r [0:NS];
  logic [pcc_pkg::Q_W-1:0]       low_r [0:NS];
  logic [pcc_pkg::SUM_W-1:0]     div_r [0:NS];
  logic [pcc_pkg::STS_W-1:0]     sts_r [0:NS];
  logic                          ok_r  [0:NS];

  logic [pcc_pkg::CSUM_W-1:0]    cent;
  logic [pcc_pkg::CSUM_W-1:0]    cent_sat;
  logic [pcc_pkg::TOTX_W-1:0]    tot_x;
  logic [pcc_pkg::TOT_W-1:0]     tot_sat;

  logic                          strobe_r;
  logic [pcc_pkg::CENT_W-1:0]    centroid_r;
  logic [pcc_pkg::TOT_W-1:0]     total_r;
  logic                          cvalid_r;

  assign pop  = in_vld;
  assign prod = pcc_pkg::WS_W'(in_evt.wsum) * (pcc_pkg::WS_W + pcc_pkg::SCALE_W)'(strip_scale);
  assign dvd  = {prod, {pcc_pkg::FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  // the high part of the dividend is already below the divisor
  always_ff @(posedge clk) begin
    rem_r[0] <= dvd[pcc_pkg::DV_W-1:pcc_pkg::Q_W];
    low_r[0] <= dvd[pcc_pkg::Q_W-1:0];
    div_r[0] <= in_evt.sum;
    sts_r[0] <= in_evt.sts;
    ok_r[0]  <= in_evt.valid;
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [pcc_pkg::SUM_W:0] trial;
    logic [pcc_pkg::SUM_W:0] diff;
    logic                    ge;

    assign trial = {rem_r[k-1], low_r[k-1][pcc_pkg::Q_W-1]};
    assign diff  = trial - {1'b0, div_r[k-1]};
    assign ge    = (trial >= {1'b0, div_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[pcc_pkg::SUM_W-1:0] : trial[pcc_pkg::SUM_W-1:0];
      low_r[k] <= {low_r[k-1][pcc_pkg::Q_W-2:0], ge};
      div_r[k] <= div_r[k-1];
      sts_r[k] <= sts_r[k-1];
      ok_r[k]  <= ok_r[k-1];
    end
  end

  always_comb begin
    cent     = (pcc_pkg::CSUM_W'(sts_r[NS]) << pcc_pkg::FRAC_W)
               + pcc_pkg::CSUM_W'(low_r[NS]);
    cent_sat = (cent > pcc_pkg::CENT_MAX) ? pcc_pkg::CENT_MAX : cent;
    tot_x    = pcc_pkg::TOTX_W'(div_r[NS]);
    tot_sat  = (tot_x > pcc_pkg::TOT_MAX) ? pcc_pkg::TOT_MAX[pcc_pkg::TOT_W-1:0]
                                          : tot_x[pcc_pkg::TOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    centroid_r <= ok_r[NS] ? cent_sat[pcc_pkg::CENT_W-1:0] : '0;
    total_r    <= tot_sat;
    cvalid_r   <= ok_r[NS];
  end

  assign res_strobe   = strobe_r;
  assign res_centroid = centroid_r;
  assign res_total    = total_r;
  assign res_cvalid   = cvalid_r;

endmodule

// File: src/pad_charge_centroid_unit.sv
// Pad charge centroid unit: center-of-gravity position of one detector event.
//
// Input channel: raise start with in_start_strip, in_pad_count and the eight
// pad charges; the transaction is taken at the edge where start is high and
// busy is low. One event may be taken every cycle.
// Result channel: out_strobe is high for exactly one cycle per event, with
// out_centroid (8 fraction bits, zero when rejected), out_total_charge and
// out_centroid_valid. The receiver cannot stall; results appear in input order.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register (0 strip_scale, 1 min_pads), cfg_data carries the value.
// cfg_ready is always high. Write only while no event is in flight.
// The accepting edge loads the front registers; the event then passes the queue,
// the divider input register, Q_W = 19 divider stages (one quotient bit each)
// and the output register. Throughput: one event per cycle while busy is low.
// The front stage, a two-entry queue and the divider pipeline sit in a row;
// busy rises only when the queue is full.
// Reset: clears all in-flight events, the queue and output strobe, and
// loads strip_scale = 10, min_pads = 2.
module pad_charge_centroid_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [pcc_pkg::START_W-1:0]         in_start_strip,
  input  logic [pcc_pkg::CNT_W-1:0]           in_pad_count,
  input  logic [pcc_pkg::CHG_W-1:0]           in_charge_0,
  input  logic [pcc_pkg::CHG_W-1:0]           in_charge_1,
  input  logic [pcc_pkg::CHG_W-1:0]           in_charge_2,
  input  logic [pcc_pkg::CHG_W-1:0]           in_charge_3,
  input  logic [pcc_pkg::CHG_W-1:0]           in_charge_4,
  input  logic [pcc_pkg::CHG_W-1:0]           in_charge_5,
  input  logic [pcc_pkg::CHG_W-1:0]           in_charge_6,
  input  logic [pcc_pkg::CHG_W-1:0]           in_charge_7,
  output logic                                out_strobe,
  output logic [pcc_pkg::CENT_W-1:0]          out_centroid,
  output logic [pcc_pkg::TOT_W-1:0]           out_total_charge,
  output logic                                out_centroid_valid,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [pcc_pkg::SCALE_W-1:0] strip_scale_r;
  logic [pcc_pkg::CNT_W-1:0]   min_pads_r;
  pcc_pkg::charges_t           charges;
  pcc_pkg::evt_t               push_data;
  pcc_pkg::evt_t               head;
  logic                        push;
  logic                        pop;
  logic                        not_empty;
  logic                        q_full;

  // Config registers: always ready, unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_scale_r <= pcc_pkg::STRIP_SCALE_RST;
      min_pads_r    <= pcc_pkg::MIN_PADS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcc_pkg::REG_STRIP_SCALE: strip_scale_r <= cfg_data[pcc_pkg::SCALE_W-1:0];
        pcc_pkg::REG_MIN_PADS:    min_pads_r    <= cfg_data[pcc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pack the pad charges, pad 0 in the low slot.
  assign charges = {in_charge_7, in_charge_6, in_charge_5, in_charge_4,
                    in_charge_3, in_charge_2, in_charge_1, in_charge_0};

  // Front: take the transaction, select pads, form the sums.
  pcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .start_strip (in_start_strip),
    .pad_count   (in_pad_count),
    .charges     (charges),
    .strip_scale (strip_scale_r),
    .min_pads    (min_pads_r),
    .q_full      (q_full),
    .q_push      (push),
    .q_data      (push_data)
  );

  // Queue: hold classified events between front and divider.
  pcc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (q_full)
  );

  // Back: pipelined division of the weighted part, add the start, saturate.
  pcc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (not_empty),
    .in_evt       (head),
    .strip_scale  (strip_scale_r),
    .pop          (pop),
    .res_strobe   (out_strobe),
    .res_centroid (out_centroid),
    .res_total    (out_total_charge),
    .res_cvalid   (out_centroid_valid)
  );

endmodule

// File: src/pcc_checker.sv
module pcc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            busy,
  input logic                            out_strobe,
  input logic [pcc_pkg::CENT_W-1:0]      out_centroid,
  input logic [pcc_pkg::TOT_W-1:0]       out_total_charge,
  input logic                            out_centroid_valid
);

  a_no_strobe_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  a_no_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy right after reset");

  a_valid_has_charge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_centroid_valid) |-> (out_total_charge != '0))
    else $error("accepted event with zero total charge");

  a_reject_zero_centroid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_centroid_valid) |-> (out_centroid == '0))
    else $error("rejected event with nonzero centroid");

endmodule

bind pad_charge_centroid_unit pcc_checker u_pcc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_centroid       (out_centroid),
  .out_total_charge   (out_total_charge),
  .out_centroid_valid (out_centroid_valid)
);

// File: dv/pcc_centroid_checker.sv
`timescale 1ns / 100ps

module pcc_centroid_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [pcc_pkg::START_W-1:0]    in_start_strip,
  input  logic [pcc_pkg::CNT_W-1:0]      in_pad_count,
  input  logic [pcc_pkg::CHG_W-1:0]      in_charge_0,
  input  logic [pcc_pkg::CHG_W-1:0]      in_charge_1,
  input  logic [pcc_pkg::CHG_W-1:0]      in_charge_2,
  input  logic [pcc_pkg::CHG_W-1:0]      in_charge_3,
  input  logic [pcc_pkg::CHG_W-1:0]      in_charge_4,
  input  logic [pcc_pkg::CHG_W-1:0]      in_charge_5,
  input  logic [pcc_pkg::CHG_W-1:0]      in_charge_6,
  input  logic [pcc_pkg::CHG_W-1:0]      in_charge_7,
  input  logic                           out_strobe,
  input  logic [pcc_pkg::CENT_W-1:0]     out_centroid,
  input  logic [pcc_pkg::TOT_W-1:0]      out_total_charge,
  input  logic                           out_centroid_valid,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                    errors,
  output int unsigned                    pending
);
  import pcc_pkg::*;

  localparam longint unsigned CENT_LIMIT = (64'd1 << CENT_W) - 64'd1;
  localparam longint unsigned TOT_LIMIT  = (64'd1 << TOT_W) - 64'd1;
  localparam int unsigned     MAX_REPORTS = 200;

  typedef struct packed {
    logic [CENT_W-1:0] centroid;
    logic [TOT_W-1:0]  total;
    logic              valid;
  } centroid_res_t;

  centroid_res_t        centroid_fifo[$];
  logic [SCALE_W-1:0]   scale_reg = STRIP_SCALE_RST;
  logic [CNT_W-1:0]     min_pads_reg = MIN_PADS_RST;

  // Center of gravity over the selected pads; an odd strip skips pad 0.
  function automatic centroid_res_t centroid_of_event(
    input logic [START_W-1:0] strip,
    input logic [CNT_W-1:0]   npads,
    input charges_t           q,
    input logic [SCALE_W-1:0] scale,
    input logic [CNT_W-1:0]   min_cnt
  );
    centroid_res_t    r;
    logic [START_W-1:0] base;
    int unsigned      first_pad;
    int unsigned      stop_pad;
    longint unsigned  sum;
    longint unsigned  wsum;
    longint unsigned  num;
    longint unsigned  cent;
    base      = strip;
    first_pad = strip[0] ? 1 : 0;
    if (strip[0]) begin
      stop_pad = npads + 1;
      base     = strip - 1'b1;
    end else begin
      stop_pad = npads;
    end
    if (npads == 0) stop_pad = first_pad;
    if (stop_pad > NUM_PADS) stop_pad = NUM_PADS;
    sum  = 0;
    wsum = 0;
    for (int unsigned j = first_pad; j < stop_pad; j++) begin
      sum  += longint'(q[j]);
      wsum += longint'(q[j]) * j;
    end
    r.valid = (sum != 0) && (npads > min_cnt) && (base != 0);
    cent = 0;
    if (r.valid) begin
      num  = (longint'(base) * sum + wsum) * longint'(scale);
      cent = (num << FRAC_W) / sum;
      if (cent > CENT_LIMIT) cent = CENT_LIMIT;
    end
    r.centroid = cent[CENT_W-1:0];
    r.total    = (sum > TOT_LIMIT) ? TOT_LIMIT[TOT_W-1:0] : sum[TOT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    centroid_res_t want;
    charges_t      q;
    if (!rst_n) begin
      scale_reg    = STRIP_SCALE_RST;
      min_pads_reg = MIN_PADS_RST;
      centroid_fifo.delete();
    end else begin
      if (out_strobe) begin
        if (centroid_fifo.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result: centroid %0d total %0d valid %0b",
                     $time, out_centroid, out_total_charge, out_centroid_valid);
        end else begin
          want = centroid_fifo.pop_front();
          if (out_centroid !== want.centroid || out_total_charge !== want.total ||
              out_centroid_valid !== want.valid) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: mismatch: expected centroid %0d total %0d valid %0b, %s",
                       $time, want.centroid, want.total, want.valid,
                       $sformatf("got centroid %0d total %0d valid %0b",
                                 out_centroid, out_total_charge, out_centroid_valid));
          end
        end
      end
      if (start && !busy) begin
        q = {in_charge_7, in_charge_6, in_charge_5, in_charge_4,
             in_charge_3, in_charge_2, in_charge_1, in_charge_0};
        centroid_fifo.push_back(centroid_of_event(in_start_strip, in_pad_count, q,
                                                  scale_reg, min_pads_reg));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STRIP_SCALE: scale_reg = cfg_data[SCALE_W-1:0];
          REG_MIN_PADS:    min_pads_reg = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= centroid_fifo.size();
  end

endmodule

// File: dv/tb_pad_charge_centroid_unit.sv
`timescale 1ns / 100ps

module tb_pad_charge_centroid_unit;
  import pcc_pkg::*;

  // One detector event as the sender sees it.
  typedef struct packed {
    logic [START_W-1:0] strip;
    logic [CNT_W-1:0]   npads;
    charges_t           q;
  } pad_event_t;

  localparam int ITEMS_PER_PHASE = 180;
  localparam int NUM_PHASES      = 6;
  localparam int DRAIN_CYCLES    = 30;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [START_W-1:0]    in_start_strip = '0;
  logic [CNT_W-1:0]      in_pad_count = '0;
  logic [CHG_W-1:0]      in_charge_0 = '0;
  logic [CHG_W-1:0]      in_charge_1 = '0;
  logic [CHG_W-1:0]      in_charge_2 = '0;
  logic [CHG_W-1:0]      in_charge_3 = '0;
  logic [CHG_W-1:0]      in_charge_4 = '0;
  logic [CHG_W-1:0]      in_charge_5 = '0;
  logic [CHG_W-1:0]      in_charge_6 = '0;
  logic [CHG_W-1:0]      in_charge_7 = '0;
  logic                  out_strobe;
  logic [CENT_W-1:0]     out_centroid;
  logic [TOT_W-1:0]      out_total_charge;
  logic                  out_centroid_valid;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           errors;
  int unsigned           pending;
  int                    calm_left = 0;

  always #2 clk = ~clk;

  pad_charge_centroid_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_start_strip     (in_start_strip),
    .in_pad_count       (in_pad_count),
    .in_charge_0        (in_charge_0),
    .in_charge_1        (in_charge_1),
    .in_charge_2        (in_charge_2),
    .in_charge_3        (in_charge_3),
    .in_charge_4        (in_charge_4),
    .in_charge_5        (in_charge_5),
    .in_charge_6        (in_charge_6),
    .in_charge_7        (in_charge_7),
    .out_strobe         (out_strobe),
    .out_centroid       (out_centroid),
    .out_total_charge   (out_total_charge),
    .out_centroid_valid (out_centroid_valid),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Watch both channels and the register port, predict every event, compare.
  pcc_centroid_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_start_strip     (in_start_strip),
    .in_pad_count       (in_pad_count),
    .in_charge_0        (in_charge_0),
    .in_charge_1        (in_charge_1),
    .in_charge_2        (in_charge_2),
    .in_charge_3        (in_charge_3),
    .in_charge_4        (in_charge_4),
    .in_charge_5        (in_charge_5),
    .in_charge_6        (in_charge_6),
    .in_charge_7        (in_charge_7),
    .out_strobe         (out_strobe),
    .out_centroid       (out_centroid),
    .out_total_charge   (out_total_charge),
    .out_centroid_valid (out_centroid_valid),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .errors             (errors),
    .pending            (pending)
  );

  // Present one event and hold it until the block takes the transaction.
  // Leave start high on return; the next call or a gap decides what follows.
  // busy is read right after the edge, so it is the value the block sampled.
  task automatic send_event(input pad_event_t ev);
    start          <= 1'b1;
    in_start_strip <= ev.strip;
    in_pad_count   <= ev.npads;
    in_charge_0    <= ev.q[0];
    in_charge_1    <= ev.q[1];
    in_charge_2    <= ev.q[2];
    in_charge_3    <= ev.q[3];
    in_charge_4    <= ev.q[4];
    in_charge_5    <= ev.q[5];
    in_charge_6    <= ev.q[6];
    in_charge_7    <= ev.q[7];
    do @(posedge clk); while (busy);
  endtask

  // Insert a sender gap: mostly none or short, a few long, and now and then
  // a calm stretch of back-to-back events.
  task automatic idle_gap();
    int n;
    int r;
    n = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3)       calm_left = $urandom_range(20, 60);
      else if (r < 55) n = 0;
      else if (r < 88) n = $urandom_range(1, 3);
      else if (r < 97) n = $urandom_range(4, 12);
      else             n = $urandom_range(20, 60);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop start and hold until every predicted result has come back.
  task automatic drain_events();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write both registers back to back; call only with the block idle.
  task automatic write_settings(input logic [CFG_DATA_W-1:0] scale,
                                input logic [CFG_DATA_W-1:0] min_cnt);
    cfg_valid <= 1'b1;
    cfg_index <= REG_STRIP_SCALE;
    cfg_data  <= scale;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_MIN_PADS;
    cfg_data  <= min_cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Charges rise linearly across the pads (wrapping at 16 bits).
  task automatic send_ramp(input logic [START_W-1:0] strip, input logic [CNT_W-1:0] npads,
                           input logic [CHG_W-1:0] base, input logic [CHG_W-1:0] step);
    pad_event_t ev;
    ev.strip = strip;
    ev.npads = npads;
    for (int j = 0; j < NUM_PADS; j++) ev.q[j] = CHG_W'(base + step * j);
    send_event(ev);
    idle_gap();
  endtask

  // Charge on one pad only.
  task automatic send_single(input logic [START_W-1:0] strip, input logic [CNT_W-1:0] npads,
                             input int pad, input logic [CHG_W-1:0] val);
    pad_event_t ev;
    ev.strip  = strip;
    ev.npads  = npads;
    ev.q      = '0;
    ev.q[pad] = val;
    send_event(ev);
    idle_gap();
  endtask

  // Mostly plausible events (start above 1, a few pads) with assorted charge shapes;
  // the rest covers start strips 0, 1, 1022, 1023 and the full pad count range.
  function automatic pad_event_t random_event();
    pad_event_t ev;
    int         style;
    int         hot;
    if ($urandom_range(0, 9) < 8) begin
      ev.strip = START_W'($urandom_range(2, 1023));
    end else begin
      case ($urandom_range(0, 3))
        0:       ev.strip = 10'd0;
        1:       ev.strip = 10'd1;
        2:       ev.strip = 10'd1022;
        default: ev.strip = 10'd1023;
      endcase
    end
    if ($urandom_range(0, 9) < 7) ev.npads = CNT_W'($urandom_range(1, 9));
    else                          ev.npads = CNT_W'($urandom_range(0, 15));
    style = $urandom_range(0, 9);
    hot   = $urandom_range(0, NUM_PADS - 1);
    for (int j = 0; j < NUM_PADS; j++) begin
      case (style)
        5, 6:    ev.q[j] = CHG_W'($urandom_range(0, 255));
        7:       ev.q[j] = ($urandom_range(0, 1) != 0) ? CHG_W'($urandom) : '0;
        8:       ev.q[j] = CHG_W'($urandom_range(16'hFF00, 16'hFFFF));
        9:       ev.q[j] = (j == hot) ? CHG_W'($urandom) : '0;
        default: ev.q[j] = CHG_W'($urandom);
      endcase
    end
    return ev;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] phase_scale [NUM_PHASES];
    logic [CFG_DATA_W-1:0] phase_min [NUM_PHASES];
    phase_scale = '{8'd1, 8'd255, 8'd37, 8'd200, 8'd10, 8'd0};
    phase_min   = '{8'd0, 8'd1, 8'd3, 8'd8, 8'hA2, 8'd0};
    phase_scale[NUM_PHASES-1] = CFG_DATA_W'($urandom_range(1, 254));
    phase_min[NUM_PHASES-1]   = CFG_DATA_W'($urandom_range(0, 8));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed events under the reset settings (scale 10, min pads 2).
    send_ramp(10'd100, 4'd3, 16'd1000, 16'd500);     // even start, plain case
    send_ramp(10'd101, 4'd3, 16'd1000, 16'd500);     // odd start skips pad 0
    send_ramp(10'd100, 4'd0, 16'd1000, 16'd1);       // no pads at all
    send_ramp(10'd100, 4'd2, 16'd1000, 16'd1);       // count equal to min pads
    send_ramp(10'd0, 4'd4, 16'd1000, 16'd1);         // start zero
    send_ramp(10'd1, 4'd4, 16'd1000, 16'd1);         // odd start lowered to zero
    send_ramp(10'd200, 4'd8, 16'd0, 16'd0);          // zero total
    send_ramp(10'd300, 4'd15, 16'd100, 16'd100);     // pads beyond the last
    send_ramp(10'd301, 4'd8, 16'd100, 16'd100);      // odd start runs past pad 7
    send_ramp(10'd1022, 4'd8, 16'hFFFF, 16'd0);      // largest total
    send_ramp(10'd1023, 4'd15, 16'hFFFF, 16'd0);
    send_single(10'd2, 4'd3, 0, 16'd1);
    send_single(10'd512, 4'd8, 7, 16'hFFFF);
    send_ramp(10'd1023, 4'd7, 16'h8000, 16'h1000);

    // Top scale, no pad minimum: centroid overflow and single-pad events.
    drain_events();
    write_settings(8'd255, 8'd0);
    send_single(10'd1022, 4'd8, 7, 16'hFFFF);
    send_single(10'd1023, 4'd8, 7, 16'd1);
    send_ramp(10'd2, 4'd1, 16'd5, 16'd0);
    send_ramp(10'd1022, 4'd8, 16'hFFFF, 16'd0);

    // Zero scale still accepts; min pads at 8 needs a count of 9 or more.
    drain_events();
    write_settings(8'd0, 8'd8);
    send_ramp(10'd500, 4'd9, 16'd300, 16'd7);
    send_ramp(10'd500, 4'd8, 16'd300, 16'd7);

    // Min pads at the top of the pad count range rejects everything.
    drain_events();
    write_settings(8'd1, 8'd15);
    send_ramp(10'd500, 4'd15, 16'd300, 16'd7);
    send_ramp(10'd777, 4'd14, 16'd300, 16'd7);

    // Random events, one register setting per phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_events();
      write_settings(phase_scale[p], phase_min[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Hold the sender once mid-phase until the pipeline is empty.
        if (p == 2 && k == ITEMS_PER_PHASE / 2) drain_events();
        send_event(random_event());
        idle_gap();
      end
    end

    // Let the last results out, then watch a while for stray strobes.
    drain_events();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
